// ----- hw/rtl/jsm_pkg.sv -----
// shared types and constants of the jtag scan master
package jsm_pkg;

   // default sizing of the scan engine
   localparam int MaxScanBitsDef = 32;
   localparam int MaxPadBitsDef  = 8;
   localparam int ResetPulsesDef = 5;

   // fixed field widths
   localparam int DataW   = 32;
   localparam int LenW    = 6;
   localparam int PadW    = 4;
   localparam int OpW     = 2;
   localparam int ErrW    = 2;
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 32;

   // opcodes on the request channel
   localparam logic [OpW-1:0] OP_TICK  = 2'd0;
   localparam logic [OpW-1:0] OP_SCAN  = 2'd1;
   localparam logic [OpW-1:0] OP_RESET = 2'd2;
   localparam logic [OpW-1:0] OP_NOP   = 2'd3;

   // register indexes on the configuration port
   localparam logic [1:0] REG_DR_LEAD  = 2'd0;
   localparam logic [1:0] REG_DR_TRAIL = 2'd1;
   localparam logic [1:0] REG_IR_LEAD  = 2'd2;
   localparam logic [1:0] REG_IR_TRAIL = 2'd3;

   // error codes on the response channel
   localparam logic [ErrW-1:0] ERR_NONE     = 2'd0;
   localparam logic [ErrW-1:0] ERR_ZERO_LEN = 2'd1;
   localparam logic [ErrW-1:0] ERR_TAP_POS  = 2'd2;
   localparam logic [ErrW-1:0] ERR_BUSY     = 2'd3;

   // command class chosen by the front end
   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_SCAN,
      CMD_RESET,
      CMD_NOP
   } cmd_type;

   // one classified request waiting for the back end
   typedef struct packed {
      cmd_type              cmd;
      logic                 tdo;
      logic [DataW-1:0]     bits;
      logic [LenW-1:0]      len;
      logic                 len_zero;
      logic                 select_ir;
      logic                 end_idle;
   } item_type;

   // pad counts from the configuration registers
   typedef struct packed {
      logic [PadW-1:0] dr_lead;
      logic [PadW-1:0] dr_trail;
      logic [PadW-1:0] ir_lead;
      logic [PadW-1:0] ir_trail;
   } cfg_type;

endpackage

// ----- hw/rtl/jsm_req_if.sv -----
// request channel of the jtag scan master
interface jsm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic        tdo_in;
   logic [31:0] scan_bits;
   logic [5:0]  scan_length;
   logic        select_ir;
   logic        end_in_idle;

   modport source (output valid, opcode, tdo_in, scan_bits, scan_length, select_ir,
                   end_in_idle, input ready);
   modport sink (input valid, opcode, tdo_in, scan_bits, scan_length, select_ir,
                 end_in_idle, output ready);
endinterface

// ----- hw/rtl/jsm_rsp_if.sv -----
// response channel of the jtag scan master
interface jsm_rsp_if;
   logic        valid;
   logic        ready;
   logic        tck_pulse;
   logic        tms_out;
   logic        tdi_out;
   logic        busy_res;
   logic        done_res;
   logic [31:0] captured;
   logic [1:0]  error_code;

   modport source (output valid, tck_pulse, tms_out, tdi_out, busy_res, done_res, captured,
                   error_code, input ready);
   modport sink (input valid, tck_pulse, tms_out, tdi_out, busy_res, done_res, captured,
                 error_code, output ready);
endinterface

// ----- hw/rtl/jsm_front.sv -----
// front end: takes request transfers and classifies them into queue items
module jsm_front (
   jsm_req_if.sink          req_chan,
   output logic             push,
   output jsm_pkg::item_type push_item,
   input  logic             queue_ready
);
   import jsm_pkg::*;

   // accept whenever the queue has room
   assign req_chan.ready = queue_ready;
   assign push = req_chan.valid & queue_ready;

   // opcode decode and length check
   always_comb begin
      push_item.tdo       = req_chan.tdo_in;
      push_item.bits      = req_chan.scan_bits;
      push_item.len       = req_chan.scan_length;
      push_item.len_zero  = (req_chan.scan_length == '0);
      push_item.select_ir = req_chan.select_ir;
      push_item.end_idle  = req_chan.end_in_idle;
      unique case (req_chan.opcode)
         OP_TICK:  push_item.cmd = CMD_TICK;
         OP_SCAN:  push_item.cmd = CMD_SCAN;
         OP_RESET: push_item.cmd = CMD_RESET;
         default:  push_item.cmd = CMD_NOP;
      endcase
   end
endmodule

// ----- hw/rtl/jsm_queue.sv -----
// two-entry queue between the front and back ends
module jsm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jsm_pkg::item_type push_item,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output jsm_pkg::item_type pop_item
);
   import jsm_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

// ----- hw/rtl/jsm_back.sv -----
// back end: tap sequencer that executes one queue item per cycle while the response register is free or being taken
module jsm_back #(
   parameter int MAX_SCAN_BITS = jsm_pkg::MaxScanBitsDef,
   parameter int MAX_PAD_BITS  = jsm_pkg::MaxPadBitsDef,
   parameter int RESET_PULSES  = jsm_pkg::ResetPulsesDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  jsm_pkg::item_type item,
   output logic              pop,
   input  jsm_pkg::cfg_type  cfg,
   jsm_rsp_if.source         rsp_chan
);
   import jsm_pkg::*;

   localparam int PadMaxW = $clog2(MAX_PAD_BITS + 1);
   localparam int CntMax0 = (MAX_SCAN_BITS > DataW) ? MAX_SCAN_BITS : DataW;
   localparam int CntMax1 = (CntMax0 > MAX_PAD_BITS) ? CntMax0 : MAX_PAD_BITS;
   localparam int CntMax  = (CntMax1 > RESET_PULSES) ? CntMax1 : RESET_PULSES;
   localparam int CntW    = $clog2(CntMax + 1);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RST_HIGH,
      PH_RST_LOW,
      PH_SEL_DR,
      PH_SEL_IR,
      PH_CAPTURE,
      PH_TO_SHIFT,
      PH_LEAD,
      PH_DATA,
      PH_TRAIL,
      PH_TO_UPDATE,
      PH_FINAL
   } phase_type;

   typedef enum logic [1:0] {
      TAP_UNKNOWN,
      TAP_IDLE,
      TAP_SELDR
   } tap_type;

   // sequencer state
   phase_type           phase_ff, phase_in;
   tap_type             tap_ff, tap_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic [DataW-1:0]    out_shift_ff, out_shift_in;
   logic [DataW-1:0]    in_shift_ff, in_shift_in;
   logic [CntW-1:0]     len_ff, len_in;
   logic                is_ir_ff, is_ir_in;
   logic                end_idle_ff, end_idle_in;
   logic [PadMaxW-1:0]  lead_ff, lead_in;
   logic [PadMaxW-1:0]  trail_ff, trail_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                tck_ff, tck_in;
   logic                tms_ff, tms_in;
   logic                tdi_ff, tdi_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DataW-1:0]    cap_ff, cap_in;
   logic [ErrW-1:0]     err_ff, err_in;

   logic                busy_now;
   logic [CntW-1:0]     cnt_inc;
   logic [CntW-1:0]     lead_ext;
   logic [CntW-1:0]     trail_ext;
   logic [PadW-1:0]     lead_raw;
   logic [PadW-1:0]     trail_raw;

   assign pop       = item_valid & (~rsp_valid_ff | rsp_chan.ready);
   assign busy_now  = (phase_ff != PH_IDLE);
   assign cnt_inc   = cnt_ff + CntW'(1);
   assign lead_ext  = CntW'(lead_ff);
   assign trail_ext = CntW'(trail_ff);
   assign lead_raw  = item.select_ir ? cfg.ir_lead : cfg.dr_lead;
   assign trail_raw = item.select_ir ? cfg.ir_trail : cfg.dr_trail;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.tck_pulse  = tck_ff;
   assign rsp_chan.tms_out    = tms_ff;
   assign rsp_chan.tdi_out    = tdi_ff;
   assign rsp_chan.busy_res   = busy_ff;
   assign rsp_chan.done_res   = done_ff;
   assign rsp_chan.captured   = cap_ff;
   assign rsp_chan.error_code = err_ff;

   // next state and response for the item at the queue head
   always_comb begin
      phase_in     = phase_ff;
      tap_in       = tap_ff;
      cnt_in       = cnt_ff;
      out_shift_in = out_shift_ff;
      in_shift_in  = in_shift_ff;
      len_in       = len_ff;
      is_ir_in     = is_ir_ff;
      end_idle_in  = end_idle_ff;
      lead_in      = lead_ff;
      trail_in     = trail_ff;
      tck_in       = 1'b0;
      tms_in       = 1'b0;
      tdi_in       = 1'b0;
      done_in      = 1'b0;
      cap_in       = '0;
      err_in       = ERR_NONE;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;

      if (pop) begin
         rsp_valid_in = 1'b1;
         case (item.cmd) inside
            CMD_SCAN, CMD_RESET: begin
               if (busy_now) begin
                  err_in = ERR_BUSY;
               end else if (item.cmd == CMD_RESET) begin
                  phase_in = PH_RST_HIGH;
                  cnt_in   = '0;
               end else if (item.len_zero) begin
                  err_in = ERR_ZERO_LEN;
               end else if (tap_ff == TAP_UNKNOWN) begin
                  err_in = ERR_TAP_POS;
               end else begin
                  len_in       = (32'(item.len) > MAX_SCAN_BITS) ? CntW'(MAX_SCAN_BITS)
                                                                  : CntW'(item.len);
                  is_ir_in     = item.select_ir;
                  end_idle_in  = item.end_idle;
                  lead_in      = (32'(lead_raw) > MAX_PAD_BITS) ? PadMaxW'(MAX_PAD_BITS)
                                                                : PadMaxW'(lead_raw);
                  trail_in     = (32'(trail_raw) > MAX_PAD_BITS) ? PadMaxW'(MAX_PAD_BITS)
                                                                 : PadMaxW'(trail_raw);
                  out_shift_in = item.bits;
                  in_shift_in  = '0;
                  cnt_in       = '0;
                  if (tap_ff == TAP_IDLE) begin
                     phase_in = PH_SEL_DR;
                  end else begin
                     phase_in = item.select_ir ? PH_SEL_IR : PH_CAPTURE;
                  end
               end
            end
            CMD_TICK: begin
               if (busy_now) begin
                  tck_in = 1'b1;
                  unique case (phase_ff)
                     PH_RST_HIGH: begin
                        tms_in = 1'b1;
                        cnt_in = cnt_inc;
                        if (cnt_inc >= CntW'(RESET_PULSES)) begin
                           phase_in = PH_RST_LOW;
                           cnt_in   = '0;
                        end
                     end
                     PH_RST_LOW: begin
                        tap_in   = TAP_IDLE;
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                     end
                     PH_SEL_DR: begin
                        tms_in   = 1'b1;
                        phase_in = is_ir_ff ? PH_SEL_IR : PH_CAPTURE;
                     end
                     PH_SEL_IR: begin
                        tms_in   = 1'b1;
                        phase_in = PH_CAPTURE;
                     end
                     PH_CAPTURE: begin
                        phase_in = PH_TO_SHIFT;
                     end
                     PH_TO_SHIFT: begin
                        cnt_in   = '0;
                        phase_in = (lead_ff != '0) ? PH_LEAD : PH_DATA;
                     end
                     PH_LEAD: begin
                        tdi_in = 1'b1;
                        cnt_in = cnt_inc;
                        if (cnt_inc >= lead_ext) begin
                           cnt_in   = '0;
                           phase_in = PH_DATA;
                        end
                     end
                     PH_DATA: begin
                        // data bits go out LSB first, zeros past the loaded word
                        tdi_in       = out_shift_ff[0];
                        out_shift_in = {1'b0, out_shift_ff[DataW-1:1]};
                        if (item.tdo && (cnt_ff < CntW'(DataW))) begin
                           in_shift_in[cnt_ff[$clog2(DataW)-1:0]] = 1'b1;
                        end
                        tms_in = (cnt_inc >= len_ff) && (trail_ff == '0);
                        cnt_in = cnt_inc;
                        if (cnt_inc >= len_ff) begin
                           cnt_in   = '0;
                           phase_in = (trail_ff != '0) ? PH_TRAIL : PH_TO_UPDATE;
                        end
                     end
                     PH_TRAIL: begin
                        tdi_in = 1'b1;
                        tms_in = (cnt_inc >= trail_ext);
                        cnt_in = cnt_inc;
                        if (cnt_inc >= trail_ext) begin
                           cnt_in   = '0;
                           phase_in = PH_TO_UPDATE;
                        end
                     end
                     PH_TO_UPDATE: begin
                        tms_in   = 1'b1;
                        phase_in = PH_FINAL;
                     end
                     PH_FINAL: begin
                        tms_in   = ~end_idle_ff;
                        tap_in   = end_idle_ff ? TAP_IDLE : TAP_SELDR;
                        phase_in = PH_IDLE;
                        cnt_in   = '0;
                        done_in  = 1'b1;
                        cap_in   = in_shift_ff;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
      busy_in = (phase_in != PH_IDLE);
   end

   // state and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tap_ff       <= TAP_UNKNOWN;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff       <= cnt_in;
      out_shift_ff <= out_shift_in;
      in_shift_ff  <= in_shift_in;
      len_ff       <= len_in;
      is_ir_ff     <= is_ir_in;
      end_idle_ff  <= end_idle_in;
      lead_ff      <= lead_in;
      trail_ff     <= trail_in;
      if (pop) begin
         tck_ff  <= tck_in;
         tms_ff  <= tms_in;
         tdi_ff  <= tdi_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         cap_ff  <= cap_in;
         err_ff  <= err_in;
      end
   end
endmodule

// ----- hw/rtl/jtag_scan_master.sv -----
// jtag scan master top level: configuration registers, front end, queue and sequencer
//
// Each request transfer (a TCK tick, a scan start, a TAP reset or a no-op) yields exactly
// one response transfer, in order. The block takes one request per clock and gives one
// response per clock when the response side keeps ready high; a request's response
// passes through the two-entry queue and then the response register before it is
// presented. The rate is set by the sequencer in the back end, which updates the TAP
// phase, bit counter and shift registers for each item that it takes from the queue.
// A reset command is followed by RESET_PULSES ticks with TMS high and one tick with
// TMS low; scans are refused with a TAP position error until such a reset sequence
// completes. The user must write the pad registers over the APB-style port only while
// no item is in flight; the block itself does not enforce it.
module jtag_scan_master #(
   parameter int MAX_SCAN_BITS = jsm_pkg::MaxScanBitsDef,
   parameter int MAX_PAD_BITS  = jsm_pkg::MaxPadBitsDef,
   parameter int RESET_PULSES  = jsm_pkg::ResetPulsesDef
) (
   input  logic                           clock,
   input  logic                           reset,
   jsm_req_if.sink                        req_chan,
   jsm_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [jsm_pkg::CsrAddrW-1:0]   paddr,
   input  logic [jsm_pkg::CsrDataW-1:0]   pwdata,
   output logic [jsm_pkg::CsrDataW-1:0]   prdata,
   output logic                           pready
);
   import jsm_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic [1:0] csr_index;
   logic [PadW-1:0] read_pad;

   logic       push;
   item_type   push_item;
   logic       queue_ready;
   logic       pop;
   logic       head_valid;
   item_type   head_item;

   // configuration port: register i at byte address 4*i
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_DR_LEAD:  cfg_in.dr_lead  = pwdata[PadW-1:0];
            REG_DR_TRAIL: cfg_in.dr_trail = pwdata[PadW-1:0];
            REG_IR_LEAD:  cfg_in.ir_lead  = pwdata[PadW-1:0];
            default:      cfg_in.ir_trail = pwdata[PadW-1:0];
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_index)
         REG_DR_LEAD:  read_pad = cfg_ff.dr_lead;
         REG_DR_TRAIL: read_pad = cfg_ff.dr_trail;
         REG_IR_LEAD:  read_pad = cfg_ff.ir_lead;
         default:      read_pad = cfg_ff.ir_trail;
      endcase
      prdata = CsrDataW'(read_pad);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request classification
   jsm_front u_front (
      .req_chan    (req_chan),
      .push        (push),
      .push_item   (push_item),
      .queue_ready (queue_ready)
   );

   // decoupling queue
   jsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (queue_ready),
      .pop        (pop),
      .pop_valid  (head_valid),
      .pop_item   (head_item)
   );

   // tap sequencer and response register
   jsm_back #(
      .MAX_SCAN_BITS (MAX_SCAN_BITS),
      .MAX_PAD_BITS  (MAX_PAD_BITS),
      .RESET_PULSES  (RESET_PULSES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (head_valid),
      .item       (head_item),
      .pop        (pop),
      .cfg        (cfg_ff),
      .rsp_chan   (rsp_chan)
   );
endmodule
